/* src/ipv6f_pkg.sv */
// ----------------------------------------------------------------------------
// ipv6f_pkg
// Shared types, character codes and helpers for the IPv6 address text
// formatter.
// ----------------------------------------------------------------------------
package ipv6f_pkg;

  localparam int NPIECE    = 8;
  localparam int PIECE_W   = 16;
  localparam int CHAR_W    = 7;
  localparam int SEG_CHARS = 5;

  // ascii codes written by the formatter
  localparam logic [CHAR_W-1:0] CH_LBRACK = 7'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 7'h5D;
  localparam logic [CHAR_W-1:0] CH_COLON  = 7'h3A;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;

  // text of one piece: up to four hex digits and a colon, first char at index 0
  typedef struct packed {
    logic [SEG_CHARS-1:0][CHAR_W-1:0] chars;
    logic [2:0]                       len;
  } seg_t;

  typedef seg_t [NPIECE-1:0] frame_t;

  // result of the zero run search
  typedef struct packed {
    logic              have;
    logic [2:0]        start;
    logic [NPIECE-1:0] skip;
  } zrun_t;

  // lowercase hex digit
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      hex_char = CH_ZERO + {3'b000, nib};
    end else begin
      hex_char = CH_LOWER_A + {3'b000, nib - 4'd10};
    end
  endfunction

endpackage

/* src/ipv6f_runfind.sv */
// ----------------------------------------------------------------------------
// ipv6f_runfind
// Finds the first longest run of two or more zero pieces and marks the
// pieces that the double colon swallows.
// ----------------------------------------------------------------------------
module ipv6f_runfind (
  input  logic [ipv6f_pkg::NPIECE-1:0] zero,
  output ipv6f_pkg::zrun_t             zrun
);
  import ipv6f_pkg::*;

  logic [3:0] run_len;
  logic [3:0] best_len;
  logic [2:0] run_start;
  logic [2:0] best_start;
  logic [3:0] run_end;

  // scan left to right, keeping the earliest run on a tie
  always_comb begin
    run_len    = 4'd0;
    best_len   = 4'd0;
    run_start  = 3'd0;
    best_start = 3'd0;
    for (int i = 0; i < NPIECE; i++) begin
      if (zero[i]) begin
        if (run_len == 4'd0) begin
          run_start = 3'(i);
        end
        run_len = run_len + 4'd1;
        if (run_len >= 4'd2 && run_len > best_len) begin
          best_len   = run_len;
          best_start = run_start;
        end
      end else begin
        run_len = 4'd0;
      end
    end
  end

  assign run_end = {1'b0, best_start} + best_len;

  // pieces after the first one of the run are dropped
  always_comb begin
    zrun.have  = (best_len >= 4'd2);
    zrun.start = best_start;
    for (int i = 0; i < NPIECE; i++) begin
      zrun.skip[i] = zrun.have && (4'(i) > {1'b0, best_start}) && (4'(i) < run_end);
    end
  end

endmodule

/* src/ipv6f_lane.sv */
// ----------------------------------------------------------------------------
// ipv6f_lane
// Builds the text of one piece: hex without leading zeros and a trailing
// colon, or the double colon part, or nothing inside a compressed run.
// ----------------------------------------------------------------------------
module ipv6f_lane (
  input  logic [ipv6f_pkg::PIECE_W-1:0] piece,
  input  logic                          is_first,
  input  logic                          is_last,
  input  logic                          comp_here,
  input  logic                          skip,
  output ipv6f_pkg::seg_t               seg
);
  import ipv6f_pkg::*;

  logic [2:0] digits;
  logic [1:0] nib_sel;
  logic [3:0] nib;

  // number of significant hex digits, at least one
  always_comb begin
    if (piece[15:12] != 4'd0) begin
      digits = 3'd4;
    end else if (piece[11:8] != 4'd0) begin
      digits = 3'd3;
    end else if (piece[7:4] != 4'd0) begin
      digits = 3'd2;
    end else begin
      digits = 3'd1;
    end
  end

  // assemble the characters of this piece
  always_comb begin
    seg.chars = '0;
    seg.len   = 3'd0;
    nib_sel   = 2'd0;
    nib       = 4'd0;
    if (skip) begin
      seg.len = 3'd0;
    end else if (comp_here) begin
      seg.chars[0] = CH_COLON;
      seg.chars[1] = CH_COLON;
      seg.len      = is_first ? 3'd2 : 3'd1;
    end else begin
      for (int k = 0; k < SEG_CHARS; k++) begin
        if (3'(k) < digits) begin
          nib_sel = 2'(digits - 3'(k) - 3'd1);
          nib     = piece[nib_sel*4 +: 4];
          seg.chars[k] = hex_char(nib);
        end else if (3'(k) == digits) begin
          seg.chars[k] = CH_COLON;
        end
      end
      seg.len = digits + {2'b00, !is_last};
    end
  end

endmodule

/* src/ipv6f_serial.sv */
// ----------------------------------------------------------------------------
// ipv6f_serial
// Merging stage: holds one waiting and one active address text and sends the
// brackets and piece texts out one character per transaction.
// ----------------------------------------------------------------------------
module ipv6f_serial (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ipv6f_pkg::frame_t            frame_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ipv6f_pkg::CHAR_W-1:0] out_char,
  output logic                         out_last
);
  import ipv6f_pkg::*;

  localparam logic [3:0] SEG_OPEN  = 4'd0;
  localparam logic [3:0] SEG_CLOSE = 4'd9;

  logic       pend_valid;
  frame_t     pend;
  logic       act_valid;
  frame_t     act;
  logic [3:0] seg;
  logic [2:0] ci;

  logic [2:0]        piece_idx;
  seg_t              cur_seg;
  logic [CHAR_W-1:0] cur_char;
  logic [2:0]        cur_len;
  logic              out_free;
  logic              emit;
  logic              seg_done;
  logic              finish;
  logic              act_load;

  assign in_ready = !pend_valid;

  // current character of the active address
  always_comb begin
    piece_idx = 3'(seg - 4'd1);
    cur_seg   = act[piece_idx];
    if (seg == SEG_OPEN) begin
      cur_char = CH_LBRACK;
      cur_len  = 3'd1;
    end else if (seg == SEG_CLOSE) begin
      cur_char = CH_RBRACK;
      cur_len  = 3'd1;
    end else begin
      cur_char = cur_seg.chars[ci];
      cur_len  = cur_seg.len;
    end
  end

  // sequencing
  assign out_free = !out_valid || out_ready;
  assign emit     = act_valid && out_free && (cur_len != 3'd0);
  assign seg_done = (act_valid && cur_len == 3'd0) || (emit && ci == cur_len - 3'd1);
  assign finish   = seg_done && (seg == SEG_CLOSE);
  assign act_load = pend_valid && (!act_valid || finish);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      act_valid  <= 1'b0;
      out_valid  <= 1'b0;
      seg        <= SEG_OPEN;
      ci         <= 3'd0;
    end else begin
      if (in_valid && in_ready) begin
        pend_valid <= 1'b1;
      end else if (act_load) begin
        pend_valid <= 1'b0;
      end

      if (act_load) begin
        act_valid <= 1'b1;
        seg       <= SEG_OPEN;
        ci        <= 3'd0;
      end else if (finish) begin
        act_valid <= 1'b0;
      end else if (seg_done) begin
        seg <= seg + 4'd1;
        ci  <= 3'd0;
      end else if (emit) begin
        ci <= ci + 3'd1;
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pend <= frame_in;
    end
    if (act_load) begin
      act <= pend;
    end
    if (emit) begin
      out_char <= cur_char;
      out_last <= (seg == SEG_CLOSE);
    end
  end

`ifndef ASSERT_OFF
  a_ci_range: assert property (@(posedge clk) disable iff (rst)
    act_valid |-> (ci < 3'd5))
    else $error("char index out of range");

  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    act_valid |-> (seg <= SEG_CLOSE))
    else $error("segment index out of range");

  a_pend_pickup: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !act_valid) |=> act_valid)
    else $error("waiting address not taken up");

  a_last_bracket: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> (out_char == CH_RBRACK))
    else $error("last flag on a character other than closing bracket");
`endif

endmodule

/* src/ipv6_address_text_formatter_core.sv */
// ----------------------------------------------------------------------------
// ipv6_address_text_formatter_core
// Formats an IPv6 address as bracketed text with zero compression, one ASCII
// character per output transaction.
// ----------------------------------------------------------------------------
// An address is taken in one transaction and written out as "[...]" text, one
// character per cycle while m_tready allows, 4 to 41 characters, tlast on the
// closing bracket. Eight lanes build the text of each piece in parallel while a
// zero run search picks the first longest run of two or more zero pieces for
// the double colon. Zero pieces swallowed inside the compressed run still take
// a sequencer step with no character; the output character rate sets the
// throughput. An address passes the waiting, active and output registers before
// its first character. One address waits while another is being sent, so a new
// address is taken while earlier text is still going out.
module ipv6_address_text_formatter_core (
  input  logic         clk,
  input  logic         rst,
  // s_tdata: piece_0 [15:0], piece_1 [31:16], ... piece_7 [127:112]
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,
  // m_tdata: char_code [6:0], zero [7]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata,
  output logic         m_tlast
);
  import ipv6f_pkg::*;

  logic [NPIECE-1:0] zero;
  zrun_t             zrun;
  frame_t            frame;
  logic [CHAR_W-1:0] char_code;

  // zero flags per piece
  always_comb begin
    for (int i = 0; i < NPIECE; i++) begin
      zero[i] = (s_tdata[i*PIECE_W +: PIECE_W] == '0);
    end
  end

  ipv6f_runfind u_runfind (
    .zero (zero),
    .zrun (zrun)
  );

  // one lane per piece
  for (genvar g = 0; g < NPIECE; g++) begin : g_lane
    ipv6f_lane u_lane (
      .piece     (s_tdata[g*PIECE_W +: PIECE_W]),
      .is_first  (g == 0),
      .is_last   (g == NPIECE - 1),
      .comp_here (zrun.have && (zrun.start == 3'(g))),
      .skip      (zrun.skip[g]),
      .seg       (frame[g])
    );
  end

  ipv6f_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .frame_in  (frame),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (char_code),
    .out_last  (m_tlast)
  );

  assign m_tdata = {1'b0, char_code};

endmodule

/* bench/tb_ipv6_address_text_formatter_core.sv */
// ----------------------------------------------------------------------------
// tb_ipv6_address_text_formatter_core
// Self-checking bench for the IPv6 address text formatter. Addresses go in on
// the slave stream and the bracketed text with zero compression comes back one
// character per transaction. The bench predicts the text of each accepted
// address and checks every character against it, under random idling on both
// sides, a long output stall and a sender pause.
// ----------------------------------------------------------------------------
module tb_ipv6_address_text_formatter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ipv6f_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_STALL  = 400;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;
  logic         m_tlast;

  logic [127:0] addr_q[$];
  text_char_t   text_q[$];

  int send_idle_pct = 8;
  int recv_idle_pct = 50;
  int stall_req_cnt = 0;
  int stall_served  = 0;
  int stall_left    = 0;
  int cycles        = 0;
  int n_addr        = 0;
  int n_chars       = 0;
  int n_compressed  = 0;
  int n_errors      = 0;
  logic s_fire = 1'b0;

  ipv6_address_text_formatter_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // lowercase hex digit of one nibble
  function automatic logic [CHAR_W-1:0] nibble_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CH_ZERO + CHAR_W'(nib);
    end else begin
      return CH_LOWER_A + CHAR_W'(nib - 4'd10);
    end
  endfunction

  function automatic void push_char(input logic [CHAR_W-1:0] code, input logic last);
    text_char_t c;
    c.code = code;
    c.last = last;
    text_q.push_back(c);
  endfunction

  // expected text of one address, appended to the character queue
  function automatic void predict_text(input logic [127:0] word);
    logic [15:0] p [NPIECE];
    int          best_start;
    int          best_len;
    int          run_start;
    int          run_len;
    bit          squeeze;
    bit          skipping;
    bit          started;
    logic [3:0]  nib;
    best_start = 0;
    best_len   = 0;
    run_start  = 0;
    run_len    = 0;
    skipping   = 1'b0;
    for (int i = 0; i < NPIECE; i++) begin
      p[i] = word[16*i +: 16];
    end
    // first longest run of two or more zero pieces
    for (int i = 0; i < NPIECE; i++) begin
      if (p[i] == 16'h0) begin
        if (run_len == 0) run_start = i;
        run_len++;
        if (run_len >= 2 && run_len > best_len) begin
          best_len   = run_len;
          best_start = run_start;
        end
      end else begin
        run_len = 0;
      end
    end
    squeeze = (best_len >= 2);
    if (squeeze) n_compressed++;
    push_char(CH_LBRACK, 1'b0);
    for (int i = 0; i < NPIECE; i++) begin
      if (!(skipping && p[i] == 16'h0)) begin
        skipping = 1'b0;
        if (squeeze && best_start == i) begin
          if (i == 0) push_char(CH_COLON, 1'b0);
          push_char(CH_COLON, 1'b0);
          skipping = 1'b1;
        end else begin
          started = 1'b0;
          for (int s = 3; s >= 0; s--) begin
            nib = p[i][4*s +: 4];
            if (nib != 4'h0 || started || s == 0) begin
              push_char(nibble_char(nib), 1'b0);
              started = 1'b1;
            end
          end
          if (i != NPIECE - 1) push_char(CH_COLON, 1'b0);
        end
      end
    end
    push_char(CH_RBRACK, 1'b1);
  endfunction

  function automatic logic [127:0] addr_of(input logic [15:0] a0, a1, a2, a3,
                                           input logic [15:0] a4, a5, a6, a7);
    return {a7, a6, a5, a4, a3, a2, a1, a0};
  endfunction

  // mostly zero-heavy addresses, sometimes with a forced zero run
  function automatic logic [127:0] random_address();
    logic [127:0] w;
    int           kind;
    int           start;
    int           len;
    w = '0;
    for (int i = 0; i < NPIECE; i++) begin
      kind = $urandom_range(99);
      if (kind < 35)      w[16*i +: 16] = 16'h0;
      else if (kind < 50) w[16*i +: 16] = 16'($urandom_range(15, 1));
      else if (kind < 65) w[16*i +: 16] = 16'($urandom_range(255, 1));
      else if (kind < 80) w[16*i +: 16] = 16'($urandom_range(4095, 1));
      else                w[16*i +: 16] = 16'($urandom_range(65535));
    end
    if ($urandom_range(99) < 40) begin
      start = $urandom_range(NPIECE - 1);
      len   = $urandom_range(NPIECE - start, 1);
      for (int i = start; i < start + len; i++) w[16*i +: 16] = 16'h0;
    end
    return w;
  endfunction

  function automatic void queue_random(input int count);
    for (int i = 0; i < count; i++) addr_q.push_back(random_address());
  endfunction

  // wait until the sender is empty and every expected character has arrived
  task automatic drain();
    while (addr_q.size() != 0 || s_tvalid || text_q.size() != 0) @(negedge clk);
  endtask

  // address driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_fire) begin
      if (addr_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata  <= addr_q.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // long output stall, counted here
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_served != stall_req_cnt) begin
      stall_left   <= LONG_STALL;
      stall_served <= stall_served + 1;
    end
  end

  // character receiver
  always @(negedge clk) begin
    m_tready <= !rst && stall_left == 0 && ($urandom_range(99) >= recv_idle_pct);
  end

  // input prediction and output checking
  always @(posedge clk) begin
    text_char_t want;
    s_fire <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      predict_text(s_tdata);
      n_addr++;
    end
    if (!rst && m_tvalid && m_tready) begin
      n_chars++;
      if (text_q.size() == 0) begin
        $error("unexpected character transaction: char_code=%h last_char=%b",
               m_tdata[6:0], m_tlast);
        n_errors++;
      end else begin
        want = text_q.pop_front();
        if (m_tdata[6:0] !== want.code) begin
          $error("char_code mismatch: expected %h actual %h", want.code, m_tdata[6:0]);
          n_errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last_char mismatch: expected %b actual %b", want.last, m_tlast);
          n_errors++;
        end
        if (m_tdata[7] !== 1'b0) begin
          $error("pad bit mismatch: expected 0 actual %b", m_tdata[7]);
          n_errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed addresses
    addr_q.push_back(addr_of(0, 0, 0, 0, 0, 0, 0, 0));
    addr_q.push_back(addr_of(16'hffff, 16'hffff, 16'hffff, 16'hffff,
                             16'hffff, 16'hffff, 16'hffff, 16'hffff));
    addr_q.push_back(addr_of(0, 0, 0, 0, 0, 0, 0, 1));
    addr_q.push_back(addr_of(1, 0, 0, 0, 0, 0, 0, 0));
    addr_q.push_back(addr_of(1, 2, 3, 4, 5, 6, 0, 0));
    addr_q.push_back(addr_of(0, 0, 1, 2, 3, 4, 5, 6));
    addr_q.push_back(addr_of(1, 0, 2, 3, 4, 5, 6, 7));
    addr_q.push_back(addr_of(1, 0, 0, 2, 0, 0, 3, 4));
    addr_q.push_back(addr_of(0, 0, 1, 0, 0, 0, 2, 3));
    addr_q.push_back(addr_of(0, 1, 0, 1, 0, 1, 0, 1));
    addr_q.push_back(addr_of(16'h0001, 16'h0010, 16'h0100, 16'h1000,
                             16'habcd, 16'hef01, 16'h2345, 16'h6789));
    addr_q.push_back(addr_of(16'h8000, 0, 0, 0, 1, 0, 0, 0));
    addr_q.push_back(addr_of(0, 0, 0, 0, 1, 0, 0, 0));
    addr_q.push_back(addr_of(16'h000f, 16'h00ff, 16'h0fff, 16'hffff,
                             16'h000a, 16'h000b, 16'h000c, 16'h000d));
    addr_q.push_back(addr_of(0, 0, 0, 0, 0, 0, 1, 0));
    addr_q.push_back(addr_of(1, 0, 0, 0, 0, 0, 0, 1));
    addr_q.push_back(addr_of(16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                             16'h5555, 16'haaaa, 16'h5555, 16'haaaa));
    addr_q.push_back(addr_of(16'hffff, 0, 16'hffff, 0, 0, 16'hffff, 0, 0));
    addr_q.push_back(addr_of(0, 16'h1, 16'h2, 16'h3, 16'h4, 16'h5, 16'h6, 0));
    addr_q.push_back(addr_of(16'h2001, 16'h0db8, 0, 0, 0, 16'hff00, 16'h0042, 16'h8329));

    // sender rarely idles, receiver idles half the time
    queue_random(40);
    drain();

    // output held off while the sender keeps offering addresses
    send_idle_pct = 0;
    stall_req_cnt = stall_req_cnt + 1;
    queue_random(12);
    drain();

    // receiver rarely idles, sender idles half the time
    send_idle_pct = 50;
    recv_idle_pct = 8;
    queue_random(40);
    drain();

    // back to back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(40);
    drain();
    repeat (30) @(negedge clk);

    $display("covered %0d addresses, %0d of them with a double colon, %0d characters",
             n_addr, n_compressed, n_chars);
    $display("idling on both sides, one long output stall and a sender pause");
    if (n_errors == 0 && text_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
src/ipv6f_pkg.sv
src/ipv6f_runfind.sv
src/ipv6f_lane.sv
src/ipv6f_serial.sv
src/ipv6_address_text_formatter_core.sv
bench/tb_ipv6_address_text_formatter_core.sv
